/* rtl/core/vrrm_pkg.sv */
// ----------------------------------------------------------------------------
// vrrm_pkg
// Shared types and constants of the variable record ring manager.
// ----------------------------------------------------------------------------
package vrrm_pkg;

  localparam int BW        = 28;  // byte offset and size width
  localparam int CAPW      = BW + 1;
  localparam int SW        = 24;  // state size width
  localparam int IDXW      = 12;  // logical index width
  localparam int CNTW      = 13;  // record count width
  localparam int MBW       = 9;   // capacity register width
  localparam int LIMW      = 13;  // entry limit register width
  localparam int CFGW      = 24;  // configuration data width
  localparam int CFG_IDX_W = 2;
  localparam int MIB_SHIFT = 20;

  localparam int MB_MIN    = 16;
  localparam int MB_MAX    = 256;
  localparam int LIMIT_MIN = 64;

  localparam int MAX_ENTRIES_DEF    = 4096;
  localparam int BYTE_ADDR_BITS_DEF = 28;

  localparam logic [MBW-1:0]  CAP_MB_RST    = MBW'(16);
  localparam logic [LIMW-1:0] LIMIT_RST     = LIMW'(4096);
  localparam logic [SW-1:0]   MAX_STATE_RST = SW'(16777215);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STATE = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_TRIM  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NO_KEY    = 3'd4,
    ST_BAD_STATE = 3'd5,
    ST_CHAIN     = 3'd6
  } status_e;

  typedef struct packed {
    logic [BW-1:0] off;
    logic [BW-1:0] size;
    logic [SW-1:0] sbytes;
    logic          key;
  } entry_t;

endpackage

/* rtl/core/vrrm_desc_mem.sv */
// ----------------------------------------------------------------------------
// vrrm_desc_mem
// Descriptor table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vrrm_desc_mem #(
  parameter int DEPTH = vrrm_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(vrrm_pkg::MAX_ENTRIES_DEF)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  vrrm_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output vrrm_pkg::entry_t rdata_o
);

  vrrm_pkg::entry_t mem [DEPTH];
  vrrm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/variable_record_ring_manager.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_manager
// Descriptor manager for a byte ring of variable-size records.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one command word: write,
// find, trim or clear. Output channel (out_valid_o / out_stall_i) returns one
// result word per command. Configuration is a plain write port; a write to
// the capacity or the entry limit also empties the ring.
// One command is worked at a time; in_stall_o is high from acceptance until
// the result moves into the output register, which then holds it while the
// next command is already being worked. in_stall_o is also high in a cycle
// that carries a configuration write.
// Every descriptor access goes through the single read port of the table;
// each record visited takes an address step and an evaluate step. Clear,
// bad size and out of range go straight to the result; a write visits the
// oldest record for each check and each record dropped; a find reads the
// records walking back to the keyframe (target included), then checks each
// record from the keyframe forward; a trim reads the record at the index.
// Reset empties the ring and loads the register defaults; no table sweep.
// A stalled receiver holds the result; a further finished result waits in
// the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module variable_record_ring_manager #(
  parameter int MAX_ENTRIES    = vrrm_pkg::MAX_ENTRIES_DEF,
  parameter int BYTE_ADDR_BITS = vrrm_pkg::BYTE_ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [vrrm_pkg::BW-1:0]         record_bytes_i,
  input  logic [vrrm_pkg::SW-1:0]         state_bytes_i,
  input  logic                            keyframe_i,
  input  logic [vrrm_pkg::IDXW-1:0]       index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [vrrm_pkg::BW-1:0]         record_offset_o,
  output logic [vrrm_pkg::BW-1:0]         record_size_o,
  output logic [vrrm_pkg::IDXW-1:0]       anchor_index_o,
  output logic [vrrm_pkg::SW-1:0]         state_bytes_out_o,
  output logic [vrrm_pkg::CNTW-1:0]       held_count_o,
  output logic [vrrm_pkg::CNTW-1:0]       dropped_count_o,
  input  logic                            cfg_we_i,
  input  logic [vrrm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vrrm_pkg::CFGW-1:0]       cfg_wdata_i
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int BW   = vrrm_pkg::BW;
  localparam int CAPW = vrrm_pkg::CAPW;
  localparam int SW   = vrrm_pkg::SW;
  localparam logic [63:0] TOP_BYTES = 64'd1 << BYTE_ADDR_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EVAL = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } fsm_e;

  typedef enum logic [6:0] {
    PH_FULL = 7'b0000001,
    PH_OVL  = 7'b0000010,
    PH_FREE = 7'b0000100,
    PH_LEAD = 7'b0001000,
    PH_BACK = 7'b0010000,
    PH_FWD  = 7'b0100000,
    PH_TRIM = 7'b1000000
  } phase_e;

  fsm_e   state_q;
  phase_e phase_q;

  logic [vrrm_pkg::MBW-1:0]  cap_mb_q;
  logic [vrrm_pkg::LIMW-1:0] limit_q;
  logic [SW-1:0]             max_state_q;

  logic [IW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;
  logic [BW-1:0] bh_q, bt_q;

  logic [CW-1:0] i_q, idx_q, k_q, before_q;
  logic [SW-1:0] chain_q, st_q;
  logic [BW-1:0] wo_q, rec_q;
  logic          key_q;

  vrrm_pkg::status_e         res_status_q;
  logic [BW-1:0]             res_off_q, res_size_q;
  logic [vrrm_pkg::IDXW-1:0] res_kfi_q;
  logic [SW-1:0]             res_sbo_q;
  logic [vrrm_pkg::CNTW-1:0] res_drop_q;

  logic                      out_valid_q;
  logic [2:0]                out_status_q;
  logic [BW-1:0]             out_off_q, out_size_q;
  logic [vrrm_pkg::IDXW-1:0] out_kfi_q;
  logic [SW-1:0]             out_sbo_q;
  logic [vrrm_pkg::CNTW-1:0] out_cnt_q, out_drop_q;

  logic [CAPW-1:0]  cap;
  logic [CW-1:0]    tsize;
  logic [IW-1:0]    rd_addr, tail_next, head_next, trim_head;
  logic             mem_we, mem_re;
  vrrm_pkg::entry_t wr_entry, rd;
  logic [BW-1:0]    end_b;
  logic [CAPW-1:0]  free_b;
  logic             overlap, do_drop, in_acc, out_load;

  // ring geometry from the registers
  always_comb begin
    logic [63:0] c64;
    logic [31:0] lim;
    c64 = 64'(cap_mb_q);
    if (c64 < 64'(vrrm_pkg::MB_MIN)) c64 = 64'(vrrm_pkg::MB_MIN);
    if (c64 > 64'(vrrm_pkg::MB_MAX)) c64 = 64'(vrrm_pkg::MB_MAX);
    c64 = c64 << vrrm_pkg::MIB_SHIFT;
    if (c64 > TOP_BYTES) c64 = TOP_BYTES;
    cap = c64[CAPW-1:0];
    lim = 32'(limit_q);
    if (lim < 32'(vrrm_pkg::LIMIT_MIN)) lim = 32'(vrrm_pkg::LIMIT_MIN);
    if (lim > 32'(MAX_ENTRIES)) lim = 32'(MAX_ENTRIES);
    tsize = lim[CW-1:0];
  end

  // slot arithmetic
  always_comb begin
    logic [CW:0] s1, s2;
    logic [CW-1:0] tinc, hinc;
    s1 = (CW+1)'(tail_q) + (CW+1)'(i_q);
    if (s1 >= (CW+1)'(tsize)) s1 = s1 - (CW+1)'(tsize);
    s2 = (CW+1)'(tail_q) + (CW+1)'(idx_q) + (CW+1)'(1);
    if (s2 >= (CW+1)'(tsize)) s2 = s2 - (CW+1)'(tsize);
    trim_head = s2[IW-1:0];
    tinc = CW'(tail_q) + CW'(1);
    hinc = CW'(head_q) + CW'(1);
    tail_next = (tinc == tsize) ? '0 : tinc[IW-1:0];
    head_next = (hinc == tsize) ? '0 : hinc[IW-1:0];
    if (phase_q == PH_BACK || phase_q == PH_FWD || phase_q == PH_TRIM) begin
      rd_addr = s1[IW-1:0];
    end else begin
      rd_addr = tail_q;
    end
  end

  // tests on the descriptor just read
  always_comb begin
    logic [CAPW-1:0] e, d;
    e = CAPW'(rd.off) + CAPW'(rd.size);
    if (e >= cap) e = e - cap;
    end_b = e[BW-1:0];
    overlap = (CAPW'(rd.off) < CAPW'(wo_q) + CAPW'(rec_q)) &&
              (CAPW'(wo_q) < CAPW'(rd.off) + CAPW'(rd.size));
    d = CAPW'(bh_q - bt_q);
    if (count_q == '0) begin
      free_b = cap;
    end else if (bh_q == bt_q) begin
      free_b = '0;
    end else if (bh_q > bt_q) begin
      free_b = (d >= cap) ? '0 : cap - d;
    end else begin
      free_b = CAPW'(bt_q - bh_q);
    end
    do_drop = 1'b0;
    if (state_q == S_EVAL && count_q != '0) begin
      case (phase_q)
        PH_FULL: do_drop = (count_q >= tsize);
        PH_OVL:  do_drop = overlap;
        PH_FREE: do_drop = (free_b <= CAPW'(rec_q));
        PH_LEAD: do_drop = !rd.key;
        default: do_drop = 1'b0;
      endcase
    end
  end

  assign mem_we   = (state_q == S_PUT);
  assign mem_re   = (state_q == S_RD);
  assign wr_entry = '{off: wo_q, size: rec_q, sbytes: st_q, key: key_q};

  vrrm_desc_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (head_q),
    .wdata_i (wr_entry),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (rd)
  );

  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;
  assign in_acc     = in_valid_i && (state_q == S_IDLE) && !cfg_we_i;
  assign out_load   = (state_q == S_DONE) && !cfg_we_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FULL;
      cap_mb_q    <= vrrm_pkg::CAP_MB_RST;
      limit_q     <= vrrm_pkg::LIMIT_RST;
      max_state_q <= vrrm_pkg::MAX_STATE_RST;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      bh_q        <= '0;
      bt_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vrrm_pkg::CFG_CAPACITY, vrrm_pkg::CFG_LIMIT: begin
          if (cfg_index_i == vrrm_pkg::CFG_CAPACITY) begin
            cap_mb_q <= cfg_wdata_i[vrrm_pkg::MBW-1:0];
          end else begin
            limit_q <= cfg_wdata_i[vrrm_pkg::LIMW-1:0];
          end
          head_q  <= '0;
          tail_q  <= '0;
          count_q <= '0;
          bh_q    <= '0;
          bt_q    <= '0;
        end
        vrrm_pkg::CFG_MAX_STATE: begin
          max_state_q <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            rec_q        <= record_bytes_i;
            st_q         <= state_bytes_i;
            key_q        <= keyframe_i;
            i_q          <= CW'(index_i);
            idx_q        <= CW'(index_i);
            res_status_q <= vrrm_pkg::ST_OK;
            res_off_q    <= '0;
            res_size_q   <= '0;
            res_kfi_q    <= '0;
            res_sbo_q    <= '0;
            res_drop_q   <= '0;
            case (vrrm_pkg::op_e'(operation_i))
              vrrm_pkg::OP_WRITE: begin
                before_q <= count_q;
                phase_q  <= PH_FULL;
                if (record_bytes_i == '0 || CAPW'(record_bytes_i) >= cap) begin
                  res_status_q <= vrrm_pkg::ST_BAD_SIZE;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_RD;
                end
              end
              vrrm_pkg::OP_FIND, vrrm_pkg::OP_TRIM: begin
                phase_q <= (vrrm_pkg::op_e'(operation_i) == vrrm_pkg::OP_FIND) ?
                           PH_BACK : PH_TRIM;
                if (32'(index_i) >= 32'(count_q)) begin
                  res_status_q <= vrrm_pkg::ST_RANGE;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: begin
                head_q  <= '0;
                tail_q  <= '0;
                count_q <= '0;
                bh_q    <= '0;
                bt_q    <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (do_drop) begin
            // the last record gone leaves an empty ring at byte zero
            bt_q    <= (count_q == CW'(1)) ? '0 : end_b;
            tail_q  <= tail_next;
            count_q <= count_q - CW'(1);
            if (count_q == CW'(1)) begin
              bh_q <= '0;
            end
            state_q <= S_RD;
          end else begin
            case (phase_q)
              PH_FULL: begin
                // wrap to the ring start if the record would cross the end
                if (CAPW'(bh_q) + CAPW'(rec_q) > cap) begin
                  wo_q <= '0;
                  bh_q <= '0;
                end else begin
                  wo_q <= bh_q;
                end
                phase_q <= PH_OVL;
                state_q <= S_RD;
              end
              PH_OVL: begin
                phase_q <= PH_FREE;
                state_q <= S_RD;
              end
              PH_FREE: begin
                state_q <= S_PUT;
              end
              PH_LEAD: begin
                res_off_q  <= wo_q;
                res_drop_q <= vrrm_pkg::CNTW'((CW+1)'(before_q) + (CW+1)'(1) -
                                              (CW+1)'(count_q));
                state_q    <= S_DONE;
              end
              PH_BACK: begin
                if (rd.key) begin
                  k_q     <= i_q;
                  chain_q <= rd.sbytes;
                  if (rd.sbytes == '0 || rd.sbytes > max_state_q) begin
                    res_status_q <= vrrm_pkg::ST_BAD_STATE;
                    state_q      <= S_DONE;
                  end else begin
                    phase_q <= PH_FWD;
                    state_q <= S_RD;
                  end
                end else if (i_q == '0) begin
                  res_status_q <= vrrm_pkg::ST_NO_KEY;
                  state_q      <= S_DONE;
                end else begin
                  i_q     <= i_q - CW'(1);
                  state_q <= S_RD;
                end
              end
              PH_FWD: begin
                if (rd.sbytes != chain_q ||
                    CAPW'(rd.off) + CAPW'(rd.size) > cap) begin
                  res_status_q <= vrrm_pkg::ST_CHAIN;
                  state_q      <= S_DONE;
                end else if (i_q == idx_q) begin
                  res_off_q  <= rd.off;
                  res_size_q <= rd.size;
                  res_kfi_q  <= vrrm_pkg::IDXW'(k_q);
                  res_sbo_q  <= chain_q;
                  state_q    <= S_DONE;
                end else begin
                  i_q     <= i_q + CW'(1);
                  state_q <= S_RD;
                end
              end
              default: begin
                count_q <= idx_q + CW'(1);
                head_q  <= trim_head;
                bh_q    <= end_b;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_PUT: begin
          // record lands at head_q this cycle; the next read sees it
          if (CAPW'(wo_q) + CAPW'(rec_q) >= cap) begin
            bh_q <= '0;
          end else begin
            bh_q <= wo_q + rec_q;
          end
          head_q  <= head_next;
          count_q <= count_q + CW'(1);
          phase_q <= PH_LEAD;
          state_q <= S_RD;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_size_q   <= res_size_q;
      out_kfi_q    <= res_kfi_q;
      out_sbo_q    <= res_sbo_q;
      out_cnt_q    <= vrrm_pkg::CNTW'(count_q);
      out_drop_q   <= res_drop_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign record_offset_o   = out_off_q;
  assign record_size_o     = out_size_q;
  assign anchor_index_o    = out_kfi_q;
  assign state_bytes_out_o = out_sbo_q;
  assign held_count_o      = out_cnt_q;
  assign dropped_count_o   = out_drop_q;

endmodule

/* rtl/core/vrrm_checker.sv */
// ----------------------------------------------------------------------------
// vrrm_checker
// Port-level checks of the variable record ring manager.
// ----------------------------------------------------------------------------
module vrrm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [2:0]                 status_o,
  input logic [vrrm_pkg::BW-1:0]    record_offset_o,
  input logic [vrrm_pkg::CNTW-1:0]  dropped_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word lost while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(record_offset_o))
    else $error("stalled result word changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken without going busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != vrrm_pkg::ST_NO_SPACE && status_o <= vrrm_pkg::ST_CHAIN)
    else $error("illegal status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != vrrm_pkg::ST_OK |->
      dropped_count_o == '0 && record_offset_o == '0)
    else $error("failed command reports offset or drops");

endmodule

bind variable_record_ring_manager vrrm_checker u_vrrm_checker (.*);

/* test/variable_record_ring_manager_test.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_manager_test
// Self-checking bench for the record ring manager. A directed table covers
// reset behavior, size errors, range errors, wrap to zero and chain checks.
// Random command streams follow under several ring geometries and idle
// patterns. Results are checked against a ring model or a typed row result.
// ----------------------------------------------------------------------------
module variable_record_ring_manager_test;

  localparam int DEPTH     = vrrm_pkg::MAX_ENTRIES_DEF;
  localparam int BW        = vrrm_pkg::BW;
  localparam int SW        = vrrm_pkg::SW;
  localparam int IDXW      = vrrm_pkg::IDXW;
  localparam int CNTW      = vrrm_pkg::CNTW;
  localparam int CFGW      = vrrm_pkg::CFGW;
  localparam int CFG_IDX_W = vrrm_pkg::CFG_IDX_W;
  localparam int MBW       = vrrm_pkg::MBW;
  localparam int LIMW      = vrrm_pkg::LIMW;

  typedef struct {
    logic [2:0]      status;
    logic [BW-1:0]   off;
    logic [BW-1:0]   size;
    logic [IDXW-1:0] kfi;
    logic [SW-1:0]   sbytes;
    logic [CNTW-1:0] count;
    logic [CNTW-1:0] dropped;
  } outcome_t;

  typedef struct {
    vrrm_pkg::op_e   op;
    logic [BW-1:0]   rec;
    logic [SW-1:0]   st;
    logic            key;
    logic [IDXW-1:0] idx;
    bit              typed;
    outcome_t        want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [BW-1:0] record_bytes_i = '0;
  logic [SW-1:0] state_bytes_i = '0;
  logic keyframe_i = 1'b0;
  logic [IDXW-1:0] index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [BW-1:0] record_offset_o;
  logic [BW-1:0] record_size_o;
  logic [IDXW-1:0] anchor_index_o;
  logic [SW-1:0] state_bytes_out_o;
  logic [CNTW-1:0] held_count_o;
  logic [CNTW-1:0] dropped_count_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFGW-1:0] cfg_wdata_i = '0;

  variable_record_ring_manager i_dut (.*);

  // ring model state
  logic [BW-1:0] m_off [DEPTH];
  logic [BW-1:0] m_size [DEPTH];
  logic [SW-1:0] m_sbytes [DEPTH];
  logic          m_key [DEPTH];
  int unsigned m_head, m_tail, m_count;
  longint unsigned m_bhead, m_btail;
  int unsigned r_mb = 16, r_limit = 4096, r_max_state = 16777215;

  outcome_t pending_results[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  logic [SW-1:0] chain_st = 1;

  function automatic longint unsigned ring_cap();
    longint unsigned mb;
    longint unsigned b;
    mb = r_mb;
    if (mb < vrrm_pkg::MB_MIN) mb = vrrm_pkg::MB_MIN;
    if (mb > vrrm_pkg::MB_MAX) mb = vrrm_pkg::MB_MAX;
    b = mb << vrrm_pkg::MIB_SHIFT;
    if (b > (64'd1 << vrrm_pkg::BYTE_ADDR_BITS_DEF)) b = 64'd1 << vrrm_pkg::BYTE_ADDR_BITS_DEF;
    return b;
  endfunction

  function automatic int unsigned slots();
    int unsigned n;
    n = r_limit;
    if (n < vrrm_pkg::LIMIT_MIN) n = vrrm_pkg::LIMIT_MIN;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic int unsigned phys(int unsigned logical);
    return (m_tail + logical) % slots();
  endfunction

  function automatic longint unsigned end_of(int unsigned s);
    longint unsigned e;
    e = longint'(m_off[s]) + m_size[s];
    if (e >= ring_cap()) e -= ring_cap();
    return e;
  endfunction

  function automatic longint unsigned free_space();
    if (m_count == 0) return ring_cap();
    if (m_bhead == m_btail) return 0;
    if (m_bhead >= m_btail)
      return (m_bhead - m_btail >= ring_cap()) ? 0 : ring_cap() - (m_bhead - m_btail);
    return m_btail - m_bhead;
  endfunction

  function automatic void drop_oldest();
    if (m_count == 0) return;
    m_btail = end_of(m_tail % slots());
    m_tail = (m_tail + 1) % slots();
    m_count--;
    if (m_count == 0) begin
      m_bhead = 0;
      m_btail = 0;
    end
  endfunction

  function automatic void empty_ring();
    m_head = 0;
    m_tail = 0;
    m_count = 0;
    m_bhead = 0;
    m_btail = 0;
  endfunction

  function automatic outcome_t ring_predict(vrrm_pkg::op_e op, logic [BW-1:0] rec,
                                            logic [SW-1:0] st, logic key,
                                            logic [IDXW-1:0] idx);
    outcome_t o;
    longint unsigned cap, wo;
    int unsigned prior, s, i, k;
    bit found;
    o = '{default: '0};
    cap = ring_cap();
    case (op)
      vrrm_pkg::OP_WRITE: begin
        if (rec == 0 || rec >= cap) begin
          o.status = vrrm_pkg::ST_BAD_SIZE;
        end else begin
          prior = m_count;
          while (m_count != 0 && m_count >= slots()) drop_oldest();
          wo = m_bhead;
          if (wo + rec > cap) begin
            wo = 0;
            m_bhead = 0;
          end
          while (m_count != 0) begin
            s = m_tail % slots();
            if (!(longint'(m_off[s]) < wo + rec && wo < longint'(m_off[s]) + m_size[s])) break;
            drop_oldest();
          end
          while (m_count != 0 && free_space() <= rec) drop_oldest();
          s = m_head % slots();
          m_off[s] = BW'(wo);
          m_size[s] = rec;
          m_sbytes[s] = st;
          m_key[s] = key;
          m_bhead = wo + rec;
          if (m_bhead >= cap) m_bhead = 0;
          m_head = (s + 1) % slots();
          m_count++;
          // leading deltas cannot be decoded
          while (m_count != 0 && !m_key[m_tail % slots()]) drop_oldest();
          o.dropped = CNTW'(prior + 1 - m_count);
          o.off = BW'(wo);
        end
      end
      vrrm_pkg::OP_FIND: begin
        if (idx >= m_count) begin
          o.status = vrrm_pkg::ST_RANGE;
        end else begin
          found = 0;
          k = 0;
          i = 32'(idx);
          forever begin
            if (m_key[phys(i)]) begin
              found = 1;
              k = i;
              break;
            end
            if (i == 0) break;
            i--;
          end
          if (!found) begin
            o.status = vrrm_pkg::ST_NO_KEY;
          end else if (m_sbytes[phys(k)] == 0 || m_sbytes[phys(k)] > r_max_state) begin
            o.status = vrrm_pkg::ST_BAD_STATE;
          end else begin
            for (i = k; i <= idx; i++) begin
              s = phys(i);
              if (m_sbytes[s] != m_sbytes[phys(k)] || longint'(m_off[s]) + m_size[s] > cap) begin
                o.status = vrrm_pkg::ST_CHAIN;
                break;
              end
            end
          end
          if (o.status == vrrm_pkg::ST_OK) begin
            o.off = m_off[phys(32'(idx))];
            o.size = m_size[phys(32'(idx))];
            o.kfi = IDXW'(k);
            o.sbytes = m_sbytes[phys(k)];
          end
        end
      end
      vrrm_pkg::OP_TRIM: begin
        if (idx >= m_count) begin
          o.status = vrrm_pkg::ST_RANGE;
        end else begin
          s = phys(32'(idx));
          m_count = 32'(idx) + 1;
          m_head = (m_tail + m_count) % slots();
          m_bhead = end_of(s);
        end
      end
      default: empty_ring();
    endcase
    o.count = CNTW'(m_count);
    return o;
  endfunction

  // drive one command word and account for it once accepted
  task automatic send_word(vrrm_pkg::op_e op, logic [BW-1:0] rec, logic [SW-1:0] st,
                           logic key, logic [IDXW-1:0] idx, bit typed, outcome_t want);
    outcome_t o;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    record_bytes_i <= rec;
    state_bytes_i <= st;
    keyframe_i <= key;
    index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    o = ring_predict(op, rec, st, key, idx);
    pending_results.push_back(typed ? want : o);
  endtask

  task automatic drain_and_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFGW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vrrm_pkg::CFG_CAPACITY: begin
        r_mb = 32'(value[MBW-1:0]);
        empty_ring();
      end
      vrrm_pkg::CFG_LIMIT: begin
        r_limit = 32'(value[LIMW-1:0]);
        empty_ring();
      end
      default: r_max_state = 32'(value);
    endcase
  endtask

  task automatic random_word();
    int unsigned r;
    int unsigned div;
    vrrm_pkg::op_e op;
    logic [BW-1:0] rec;
    logic [SW-1:0] st;
    logic key;
    logic [IDXW-1:0] idx;
    r = $urandom_range(99);
    if (r < 60) op = vrrm_pkg::OP_WRITE;
    else if (r < 86) op = vrrm_pkg::OP_FIND;
    else if (r < 97) op = vrrm_pkg::OP_TRIM;
    else op = vrrm_pkg::OP_CLEAR;
    r = $urandom_range(99);
    div = $urandom_range(8, slots() <= vrrm_pkg::LIMIT_MIN ? 2000 : 300);
    if (r < 4) rec = '0;
    else if (r < 8) rec = BW'($urandom());
    else if (r < 11) rec = BW'(ring_cap() - 64'($urandom_range(1, 0)));
    else rec = BW'($urandom_range(1, 32'(ring_cap() / div)));
    key = ($urandom_range(99) < 30);
    if (key) begin
      r = $urandom_range(99);
      if (r < 5) chain_st = '0;
      else if (r < 20) chain_st = SW'($urandom());
      else chain_st = SW'($urandom_range(1, 3));
    end
    st = ($urandom_range(99) < 90) ? chain_st : SW'($urandom());
    idx = (m_count != 0 && $urandom_range(99) < 85) ? IDXW'($urandom_range(m_count - 1))
                                                     : IDXW'($urandom());
    send_word(op, rec, st, key, idx, 1'b0, '{default: '0});
  endtask

  // directed rows: a typed result is given only where it is plain
  row_t rows[] = '{
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 0, 1, '{vrrm_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0}},
    '{vrrm_pkg::OP_TRIM, 0, 0, 0, 12'hFFF, 1, '{vrrm_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0}},
    '{vrrm_pkg::OP_WRITE, 0, 0, 1, 0, 1, '{vrrm_pkg::ST_BAD_SIZE, 0, 0, 0, 0, 0, 0}},
    '{vrrm_pkg::OP_WRITE, 28'd16777216, 7, 1, 0, 1,
      '{vrrm_pkg::ST_BAD_SIZE, 0, 0, 0, 0, 0, 0}},
    '{vrrm_pkg::OP_WRITE, 28'hFFFFFFF, 24'hFFFFFF, 1, 0, 1,
      '{vrrm_pkg::ST_BAD_SIZE, 0, 0, 0, 0, 0, 0}},
    // delta into empty history is dropped at once
    '{vrrm_pkg::OP_WRITE, 100, 5, 0, 0, 1, '{vrrm_pkg::ST_OK, 0, 0, 0, 0, 0, 1}},
    '{vrrm_pkg::OP_WRITE, 1000, 50, 1, 0, 1, '{vrrm_pkg::ST_OK, 0, 0, 0, 0, 1, 0}},
    '{vrrm_pkg::OP_WRITE, 1000, 50, 0, 0, 1, '{vrrm_pkg::ST_OK, 1000, 0, 0, 0, 2, 0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 1, 1, '{vrrm_pkg::ST_OK, 1000, 1000, 0, 50, 2, 0}},
    '{vrrm_pkg::OP_WRITE, 1, 50, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 28'd16777215, 51, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 28'd8000000, 24'hFFFFFF, 1, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 28'd8000000, 24'hFFFFFF, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 28'd8000000, 24'h123456, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 1, 0, '{default: '0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 300, 0, 1, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 12'hFFF, 0, '{default: '0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_TRIM, 0, 0, 0, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_WRITE, 500, 9, 1, 0, 0, '{default: '0}},
    '{vrrm_pkg::OP_CLEAR, 0, 0, 0, 0, 1, '{vrrm_pkg::ST_OK, 0, 0, 0, 0, 0, 0}},
    '{vrrm_pkg::OP_FIND, 0, 0, 0, 0, 1, '{vrrm_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0}}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result checking and receiver stall
  initial begin
    outcome_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word, status %0d", status_o);
          errors++;
        end else begin
          w = pending_results.pop_front();
          if (status_o !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status_o); errors++;
          end
          if (record_offset_o !== w.off) begin
            $error("record_offset: expected %0d, got %0d", w.off, record_offset_o); errors++;
          end
          if (record_size_o !== w.size) begin
            $error("record_size: expected %0d, got %0d", w.size, record_size_o); errors++;
          end
          if (anchor_index_o !== w.kfi) begin
            $error("anchor_index: expected %0d, got %0d", w.kfi, anchor_index_o); errors++;
          end
          if (state_bytes_out_o !== w.sbytes) begin
            $error("state_bytes_out: expected %0d, got %0d", w.sbytes, state_bytes_out_o);
            errors++;
          end
          if (held_count_o !== w.count) begin
            $error("held_count: expected %0d, got %0d", w.count, held_count_o); errors++;
          end
          if (dropped_count_o !== w.dropped) begin
            $error("dropped_count: expected %0d, got %0d", w.dropped, dropped_count_o); errors++;
          end
        end
      end
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #2000000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned cfg_cap[6] = '{16, 511, 0, 256, 100, 16};
    int unsigned cfg_lim[6] = '{4096, 64, 0, 8191, 200, 4096};
    int unsigned cfg_max[6] = '{16777215, 1, 16777215, 2, 0, 16777215};
    empty_ring();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 23;
    recv_idle = 56;
    foreach (rows[n])
      send_word(rows[n].op, rows[n].rec, rows[n].st, rows[n].key, rows[n].idx,
                rows[n].typed, rows[n].want);
    for (int p = 0; p < 6; p++) begin
      drain_and_idle();
      send_idle = p < 2 ? 23 : p < 4 ? 56 : 0;
      recv_idle = p < 2 ? 56 : p < 4 ? 23 : 0;
      write_reg(vrrm_pkg::CFG_CAPACITY, CFGW'(cfg_cap[p]));
      write_reg(vrrm_pkg::CFG_LIMIT, CFGW'(cfg_lim[p]));
      write_reg(vrrm_pkg::CFG_MAX_STATE, CFGW'(cfg_max[p]));
      repeat (188) random_word();
    end
    drain_and_idle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/vrrm_pkg.sv
rtl/core/vrrm_desc_mem.sv
rtl/core/variable_record_ring_manager.sv
rtl/core/vrrm_checker.sv
test/variable_record_ring_manager_test.sv
